[rtl/core/mrrf_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mrrf_pkg: shared types and constants of the request framer
// Item layout, frame byte codes and the byte-wise CRC-16/Modbus update.
// ---------------------------------------------------------------------------
package mrrf_pkg;

   localparam int ByteW      = 8;
   localparam int AddrW      = 16;
   localparam int CountW     = 7;
   localparam int WordW      = 16;
   localparam int LenW       = 9;
   localparam int MaxBytes   = 7;
   localparam int IdxW       = 3;
   localparam int ReqDataW   = 56;
   localparam int RspDataW   = 24;

   localparam logic [15:0] CrcPoly = 16'hA001;
   localparam logic [15:0] CrcInit = 16'hFFFF;
   localparam logic [7:0]  MultiWriteReset = 8'd16;
   localparam logic [7:0]  ByteMask = 8'hFF;

   // item kinds
   localparam logic CmdHeader = 1'b0;
   localparam logic CmdData   = 1'b1;

   // byte positions inside one item
   localparam logic [IdxW-1:0] IdxHeaderLast = 3'd3;
   localparam logic [IdxW-1:0] IdxMultiLast  = 3'd6;
   localparam logic [IdxW-1:0] IdxWordLast   = 3'd1;
   localparam logic [IdxW-1:0] IdxCrcLo      = 3'd2;
   localparam logic [IdxW-1:0] IdxCrcHi      = 3'd3;

   typedef struct packed {
      logic              cmd;
      logic [ByteW-1:0]  dev_addr;
      logic [ByteW-1:0]  func_code;
      logic [AddrW-1:0]  start_addr;
      logic [CountW-1:0] reg_count;
      logic [WordW-1:0]  data_word;
      logic              last_word;
   } req_item_type;

   typedef struct packed {
      logic [ByteW-1:0] out_byte;
      logic             frame_end;
      logic             run_end;
      logic [LenW-1:0]  frame_length;
   } rsp_item_type;

   // one byte through the reflected crc, eight shift steps
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[rtl/core/modbus_rtu_request_framer_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// modbus_rtu_request_framer_core: Modbus RTU request frame builder
// Header and data words in, request bytes with CRC-16/Modbus out.
// ---------------------------------------------------------------------------
// A header word gives 4 bytes (7 when the function code matches the
// multi-write code), a data word gives 2 bytes, and the data word marked
// last gives 4 (its two bytes plus CRC low and high). Bytes leave one per
// cycle through the byte-wide output register while it is not stalled; a
// word holds the sequencer until its last byte has gone into that register.
// The CRC is advanced by each frame byte before the CRC bytes as it leaves.
// A data word with no frame open is taken and dropped without output. The
// next word is accepted into the input register while the current one is
// still being sent.
module modbus_rtu_request_framer_core import mrrf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [7:0]          csr_wr_data,  // multi_write_code
   input  logic                req_tvalid,
   output logic                req_tready,
   // dev_addr[7:0], func_code[15:8], start_addr[31:16], reg_count[38:32],
   // data_word[54:39], zero pad[55]
   input  logic [ReqDataW-1:0] req_tdata,
   input  logic                req_tuser,    // cmd
   input  logic                req_tlast,    // last_word
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // out_byte[7:0], frame_length[16:8], zero pad[23:17]
   output logic [RspDataW-1:0] rsp_tdata,
   output logic                rsp_tuser,    // run_end
   output logic                rsp_tlast     // frame_end
);

   req_item_type req_item, item;
   rsp_item_type rsp_item;
   logic         item_valid, item_take;

   // unpack input word
   assign req_item.cmd        = req_tuser;
   assign req_item.dev_addr   = req_tdata[7:0];
   assign req_item.func_code  = req_tdata[15:8];
   assign req_item.start_addr = req_tdata[31:16];
   assign req_item.reg_count  = req_tdata[38:32];
   assign req_item.data_word  = req_tdata[54:39];
   assign req_item.last_word  = req_tlast;

   mrrf_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   mrrf_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_valid  (item_valid),
      .item        (item),
      .item_take   (item_take),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_item    (rsp_item)
   );

   // pack output word
   assign rsp_tdata = {7'd0, rsp_item.frame_length, rsp_item.out_byte};
   assign rsp_tuser = rsp_item.run_end;
   assign rsp_tlast = rsp_item.frame_end;

endmodule

[rtl/core/mrrf_in_stage.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mrrf_in_stage: input word register
// Holds one accepted request word until the byte sequencer takes it.
// ---------------------------------------------------------------------------
module mrrf_in_stage import mrrf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  req_item_type req_item,
   output logic         item_valid,
   output req_item_type item,
   input  logic         item_take
);

   logic         valid_ff, valid_in;
   req_item_type item_ff;

   // free when empty or when the held word leaves this cycle
   assign req_tready = !valid_ff || item_take;
   assign valid_in   = (req_tvalid && req_tready) ? 1'b1 : (item_take ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[rtl/core/mrrf_seq.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mrrf_seq: frame byte sequencer
// Expands one word into frame bytes, runs the CRC and drives the output
// register, one byte per cycle while the output is not stalled.
// ---------------------------------------------------------------------------
module mrrf_seq import mrrf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [7:0]   csr_wr_data,
   input  logic         item_valid,
   input  req_item_type item,
   output logic         item_take,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output rsp_item_type rsp_item
);

   logic [7:0]      mw_code_ff;
   logic            busy_ff, busy_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic [IdxW-1:0] last_idx_ff, last_idx_in;
   logic            crc_tail_ff, crc_tail_in;
   logic [ByteW-1:0] bytes_ff [MaxBytes];
   logic [ByteW-1:0] bytes_in [MaxBytes];
   logic [15:0]     crc_ff, crc_in;
   logic [LenW-1:0] total_ff, total_in;
   logic            open_ff, open_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_item_type    rsp_ff, rsp_in;

   logic            out_free, emit, last_emit, is_crc_lo, is_crc_hi;
   logic            open_eff, load, is_header, multi;
   logic [ByteW-1:0] cur_byte;
   logic [LenW-1:0] total_inc;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         mw_code_ff <= MultiWriteReset;
      end else if (csr_wr_en) begin
         mw_code_ff <= csr_wr_data;
      end
   end

   // emit control
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign emit      = busy_ff && out_free;
   assign last_emit = emit && (idx_ff == last_idx_ff);
   assign is_crc_lo = crc_tail_ff && (idx_ff == IdxCrcLo);
   assign is_crc_hi = crc_tail_ff && (idx_ff == IdxCrcHi);
   assign cur_byte  = is_crc_lo ? crc_ff[7:0] : (is_crc_hi ? crc_ff[15:8] : bytes_ff[idx_ff]);
   assign total_inc = total_ff + LenW'(1);

   // frame still open once the current byte has gone
   assign open_eff  = open_ff && !(emit && is_crc_hi);
   assign item_take = item_valid && (!busy_ff || last_emit);
   assign is_header = (item.cmd == CmdHeader);
   assign load      = item_take && (is_header || open_eff);
   assign multi     = (item.func_code == mw_code_ff);

   // byte list of the incoming word
   always_comb begin
      for (int i = 0; i < MaxBytes; i++) begin
         bytes_in[i] = bytes_ff[i];
      end
      last_idx_in = last_idx_ff;
      crc_tail_in = crc_tail_ff;
      if (load) begin
         if (is_header) begin
            bytes_in[0] = item.dev_addr;
            bytes_in[1] = item.func_code;
            bytes_in[2] = item.start_addr[15:8];
            bytes_in[3] = item.start_addr[7:0] & ByteMask;
            bytes_in[4] = 8'h00;
            bytes_in[5] = {1'b0, item.reg_count};
            bytes_in[6] = {item.reg_count, 1'b0};
            last_idx_in = multi ? IdxMultiLast : IdxHeaderLast;
            crc_tail_in = 1'b0;
         end else begin
            bytes_in[0] = item.data_word[15:8];
            bytes_in[1] = item.data_word[7:0] & ByteMask;
            last_idx_in = item.last_word ? IdxCrcHi : IdxWordLast;
            crc_tail_in = item.last_word;
         end
      end
   end

   // frame state
   always_comb begin
      busy_in  = load ? 1'b1 : (last_emit ? 1'b0 : busy_ff);
      idx_in   = load ? '0 : (emit ? idx_ff + IdxW'(1) : idx_ff);
      crc_in   = crc_ff;
      total_in = total_ff;
      open_in  = open_ff;
      if (emit) begin
         if (is_crc_hi) begin
            crc_in   = CrcInit;
            total_in = '0;
            open_in  = 1'b0;
         end else begin
            total_in = total_inc;
            if (!is_crc_lo) begin
               crc_in = crc_byte(crc_ff, cur_byte);
            end
         end
      end
      if (load && is_header) begin
         crc_in   = CrcInit;
         total_in = '0;
         open_in  = 1'b1;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_in.out_byte     = cur_byte;
         rsp_in.frame_end    = is_crc_hi;
         rsp_in.run_end      = (idx_ff == last_idx_ff);
         rsp_in.frame_length = is_crc_hi ? total_inc : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         last_idx_ff  <= '0;
         crc_tail_ff  <= 1'b0;
         crc_ff       <= CrcInit;
         total_ff     <= '0;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         last_idx_ff  <= last_idx_in;
         crc_tail_ff  <= crc_tail_in;
         crc_ff       <= crc_in;
         total_ff     <= total_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < MaxBytes; i++) begin
         bytes_ff[i] <= bytes_in[i];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

endmodule

[rtl/core/mrrf_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mrrf_checker: port-level checks of the request framer
// Watches the result channel over time; bound to the top level.
// ---------------------------------------------------------------------------
module mrrf_checker import mrrf_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RspDataW-1:0] rsp_tdata,
   input logic                rsp_tuser,
   input logic                rsp_tlast
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // the frame end byte is always the last byte of its word
   a_end_is_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("frame end without run end");

   // frame length only shown on the frame end byte
   a_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[16:8] == 9'd0)
      else $error("frame length outside frame end");

   // nothing pending right after reset
   a_reset_idle: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind modbus_rtu_request_framer_core mrrf_checker u_mrrf_checker (.*);
